[hw/rtl/ssg_pkg.sv]
package ssg_pkg;

  localparam int ADDR_W    = 20;
  localparam int BITS_W    = 16;
  localparam int BIT_IDX_W = $clog2(BITS_W);
  localparam int COLOR_W   = 24;
  localparam int SPANB_W   = 4;
  localparam int WIDTH_W   = 5;
  localparam int SCALE_W   = 3;
  localparam int PIX_W     = SCALE_W + 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  localparam int DEF_SCREEN_PIXELS_WIDE = 640;
  localparam int DEF_BYTES_PER_PIXEL    = 3;
  localparam int DEF_MAX_SPRITE_WIDTH   = 16;
  localparam int DEF_MAX_SCALE          = 4;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(5);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRITE_WIDTH = 1'b0,
    REG_SCALE        = 1'b1
  } cfg_reg_t;

  // Effective settings after clamping
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [SCALE_W-1:0] scale;
    logic [PIX_W-1:0]   pix_bytes;
  } cfg_t;

endpackage

[hw/rtl/scaled_sprite_span_generator_unit.sv]
// Scaled one-bit sprite span generator.
// Input channel (in_*): one transaction is one sprite row. in_row_bits holds the
// row with bit sprite_width-1 as the leftmost pixel; in_first_row loads the row
// base from in_position, otherwise the base carried over from the previous row
// is used. Output channel (out_*): one transaction per span of scale pixels,
// ordered left to right, then top to bottom within a pixel; out_last_span marks
// the final span of a row. A row with no set bits produces nothing.
// Config channel (cfg_*): index 0 is sprite_width, index 1 is scale; always
// ready, write only while no row is in flight.
// Timing: a row occupies the sequencer from acceptance until its last column is
// walked, and longer while the output stalls; out_valid rises once the sequencer
// reaches the first set column, after it has skipped each leading clear column.
// The sequencer produces one span per cycle on set pixels unless a held span stalls.
// in_stall is high for the whole row. While out_stall holds a span, the
// sequencer waits on its next set pixel; the output register keeps the span.
// Reset (rst_n low, synchronous): sprite_width 5, scale 1, row base 0, no
// pending output.
module scaled_sprite_span_generator_unit #(
  parameter int SCREEN_PIXELS_WIDE = ssg_pkg::DEF_SCREEN_PIXELS_WIDE,
  parameter int BYTES_PER_PIXEL    = ssg_pkg::DEF_BYTES_PER_PIXEL,
  parameter int MAX_SPRITE_WIDTH   = ssg_pkg::DEF_MAX_SPRITE_WIDTH,
  parameter int MAX_SCALE          = ssg_pkg::DEF_MAX_SCALE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssg_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssg_pkg::BITS_W-1:0]    in_row_bits,
  input  logic                          in_first_row,
  input  logic [ssg_pkg::ADDR_W-1:0]    in_position,
  input  logic [ssg_pkg::COLOR_W-1:0]   in_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssg_pkg::ADDR_W-1:0]    out_span_address,
  output logic [ssg_pkg::SPANB_W-1:0]   out_span_bytes,
  output logic [ssg_pkg::COLOR_W-1:0]   out_span_color,
  output logic                          out_last_span
);
  import ssg_pkg::*;

  cfg_t cfg;

  // Register file with clamping of the settings
  ssg_cfg #(
    .BYTES_PER_PIXEL  (BYTES_PER_PIXEL),
    .MAX_SPRITE_WIDTH (MAX_SPRITE_WIDTH),
    .MAX_SCALE        (MAX_SCALE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Column/line walker with the output register
  ssg_seq #(
    .SCREEN_PIXELS_WIDE (SCREEN_PIXELS_WIDE),
    .BYTES_PER_PIXEL    (BYTES_PER_PIXEL)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_bits      (in_row_bits),
    .in_first_row     (in_first_row),
    .in_position      (in_position),
    .in_color         (in_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span_address (out_span_address),
    .out_span_bytes   (out_span_bytes),
    .out_span_color   (out_span_color),
    .out_last_span    (out_last_span)
  );

endmodule

[hw/rtl/ssg_cfg.sv]
module ssg_cfg #(
  parameter int BYTES_PER_PIXEL  = ssg_pkg::DEF_BYTES_PER_PIXEL,
  parameter int MAX_SPRITE_WIDTH = ssg_pkg::DEF_MAX_SPRITE_WIDTH,
  parameter int MAX_SCALE        = ssg_pkg::DEF_MAX_SCALE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssg_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output ssg_pkg::cfg_t                  cfg
);
  import ssg_pkg::*;

  logic [WIDTH_W-1:0] sprite_width_r;
  logic [SCALE_W-1:0] scale_r;
  logic [WIDTH_W-1:0] width_eff;
  logic [SCALE_W-1:0] scale_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_width_r <= WIDTH_RESET;
      scale_r        <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPRITE_WIDTH: sprite_width_r <= cfg_wdata[WIDTH_W-1:0];
        REG_SCALE:        scale_r        <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width to the maximum; treat scale zero as one and clamp to the maximum
  always_comb begin
    width_eff = sprite_width_r;
    if (32'(sprite_width_r) > MAX_SPRITE_WIDTH) width_eff = WIDTH_W'(MAX_SPRITE_WIDTH);
    scale_eff = scale_r;
    if (scale_r == '0) scale_eff = SCALE_W'(1);
    else if (32'(scale_r) > MAX_SCALE) scale_eff = SCALE_W'(MAX_SCALE);
  end

  assign cfg.width     = width_eff;
  assign cfg.scale     = scale_eff;
  assign cfg.pix_bytes = PIX_W'(32'(scale_eff) * BYTES_PER_PIXEL);

endmodule

[hw/rtl/ssg_seq.sv]
module ssg_seq #(
  parameter int SCREEN_PIXELS_WIDE = ssg_pkg::DEF_SCREEN_PIXELS_WIDE,
  parameter int BYTES_PER_PIXEL    = ssg_pkg::DEF_BYTES_PER_PIXEL
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssg_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssg_pkg::BITS_W-1:0]    in_row_bits,
  input  logic                          in_first_row,
  input  logic [ssg_pkg::ADDR_W-1:0]    in_position,
  input  logic [ssg_pkg::COLOR_W-1:0]   in_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssg_pkg::ADDR_W-1:0]    out_span_address,
  output logic [ssg_pkg::SPANB_W-1:0]   out_span_bytes,
  output logic [ssg_pkg::COLOR_W-1:0]   out_span_color,
  output logic                          out_last_span
);
  import ssg_pkg::*;

  localparam int LINE_BYTES = BYTES_PER_PIXEL * SCREEN_PIXELS_WIDE;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   row_base_r, row_base_nxt;
  logic [ADDR_W-1:0]   col_r, col_nxt;
  logic [ADDR_W-1:0]   yoff_r, yoff_nxt;
  logic [SCALE_W-1:0]  y_r, y_nxt;
  logic [WIDTH_W-1:0]  jrem_r, jrem_nxt;
  logic [BITS_W-1:0]   bits_r, bits_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [SPANB_W-1:0]  out_bytes_r, out_bytes_nxt;
  logic [COLOR_W-1:0]  out_color_r, out_color_nxt;
  logic                out_last_r, out_last_nxt;

  logic [WIDTH_W-1:0]  idx;
  logic                idx_ok;
  logic                cur_bit;
  logic [BITS_W-1:0]   bit_sel;
  logic [BITS_W-1:0]   used_mask;
  logic [ADDR_W-1:0]   base;
  logic                slot_free;

  assign idx     = jrem_r - WIDTH_W'(1);
  assign idx_ok  = (32'(idx) < BITS_W);
  assign bit_sel = BITS_W'(1) << idx[BIT_IDX_W-1:0];
  assign cur_bit = idx_ok && bits_r[idx[BIT_IDX_W-1:0]];
  assign slot_free = !out_valid_r || !out_stall;
  assign used_mask = (32'(cfg.width) >= BITS_W) ? '1
                   : BITS_W'((33'(1) << cfg.width) - 33'(1));
  assign base = in_first_row ? in_position : row_base_r;

  always_comb begin
    state_nxt     = state_r;
    row_base_nxt  = row_base_r;
    col_nxt       = col_r;
    yoff_nxt      = yoff_r;
    y_nxt         = y_r;
    jrem_nxt      = jrem_r;
    bits_nxt      = bits_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_bytes_nxt = out_bytes_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          col_nxt      = base;
          row_base_nxt = base + ADDR_W'(32'(cfg.scale) * LINE_BYTES);
          bits_nxt     = in_row_bits & used_mask;
          jrem_nxt     = cfg.width;
          y_nxt        = '0;
          yoff_nxt     = '0;
          color_nxt    = in_color;
          state_nxt    = S_RUN;
        end
      end
      S_RUN: begin
        if (jrem_r == '0) begin
          state_nxt = S_IDLE;
        end else if (!cur_bit) begin
          // skip a clear column
          jrem_nxt = jrem_r - WIDTH_W'(1);
          col_nxt  = col_r + ADDR_W'(cfg.pix_bytes);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = col_r + yoff_r;
          out_bytes_nxt = cfg.pix_bytes[SPANB_W-1:0];
          out_color_nxt = color_r;
          out_last_nxt  = (y_r == cfg.scale - SCALE_W'(1)) && ((bits_r & ~bit_sel) == '0);
          if (y_r == cfg.scale - SCALE_W'(1)) begin
            y_nxt    = '0;
            yoff_nxt = '0;
            bits_nxt = bits_r & ~bit_sel;
            jrem_nxt = jrem_r - WIDTH_W'(1);
            col_nxt  = col_r + ADDR_W'(cfg.pix_bytes);
          end else begin
            y_nxt    = y_r + SCALE_W'(1);
            yoff_nxt = yoff_r + ADDR_W'(LINE_BYTES);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_base_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_base_r  <= row_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    yoff_r      <= yoff_nxt;
    y_r         <= y_nxt;
    jrem_r      <= jrem_nxt;
    bits_r      <= bits_nxt;
    color_r     <= color_nxt;
    out_addr_r  <= out_addr_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_span_address = out_addr_r;
  assign out_span_bytes   = out_bytes_r;
  assign out_span_color   = out_color_r;
  assign out_last_span    = out_last_r;

endmodule

[tb/scaled_sprite_span_generator_unit_test.sv]
module scaled_sprite_span_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssg_pkg::*;

  // Geometry of the default build, used by the span predictor
  localparam int unsigned BPP        = DEF_BYTES_PER_PIXEL;
  localparam int unsigned LINE_BYTES = DEF_BYTES_PER_PIXEL * DEF_SCREEN_PIXELS_WIDE;
  localparam int unsigned MAX_W      = DEF_MAX_SPRITE_WIDTH;
  localparam int unsigned MAX_S      = DEF_MAX_SCALE;
  localparam int unsigned LAST_POS   = 921599;

  // Covers the longest row, with some margin
  localparam int unsigned SETTLE_CYCLES    = 80;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ROWS       = 20;
  localparam int unsigned RANDOM_PHASES    = 9;

  typedef struct packed {
    logic [BITS_W-1:0]  row_bits;
    logic               first_row;
    logic [ADDR_W-1:0]  position;
    logic [COLOR_W-1:0] color;
  } sprite_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [SPANB_W-1:0] nbytes;
    logic [COLOR_W-1:0] color;
    logic               last_span;
  } span_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BITS_W-1:0]    in_row_bits = '0;
  logic                 in_first_row = 1'b0;
  logic [ADDR_W-1:0]    in_position = '0;
  logic [COLOR_W-1:0]   in_color = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    out_span_address;
  logic [SPANB_W-1:0]   out_span_bytes;
  logic [COLOR_W-1:0]   out_span_color;
  logic                 out_last_span;

  // Rows waiting for the driver, and spans predicted but not yet seen
  sprite_row_t pending_rows[$];
  span_t       expected_spans[$];

  // Predictor state: a private copy of the block's registers and row base
  logic [WIDTH_W-1:0] model_width;
  logic [SCALE_W-1:0] model_scale;
  logic [ADDR_W-1:0]  model_row_base;

  int unsigned rows_pushed   = 0;
  int unsigned rows_accepted = 0;
  int unsigned spans_checked = 0;
  int unsigned cfg_writes    = 0;
  int unsigned error_count   = 0;

  // Idle shaping, changed by the stimulus between phases
  int unsigned sender_max_gap = 0;
  int unsigned sink_max_stall = 0;
  int unsigned idle_left      = 0;
  int unsigned stall_left     = 0;
  int unsigned long_hold_left = 0;
  logic        long_hold_go   = 1'b0;

  scaled_sprite_span_generator_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_bits      (in_row_bits),
    .in_first_row     (in_first_row),
    .in_position      (in_position),
    .in_color         (in_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span_address (out_span_address),
    .out_span_bytes   (out_span_bytes),
    .out_span_color   (out_span_color),
    .out_last_span    (out_last_span)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expand one accepted row into its spans: left to right over the used bits,
  // top to bottom over the replicated lines, then step the base down by
  // scale screen lines whether or not anything was drawn.
  function automatic void predict_row_spans(sprite_row_t row);
    int unsigned w;
    int unsigned s;
    int unsigned pix;
    int unsigned final_j;
    span_t sp;
    w = (model_width > MAX_W) ? MAX_W : model_width;
    s = (model_scale == 0) ? 1 : ((model_scale > MAX_S) ? MAX_S : model_scale);
    pix = s * BPP;
    if (row.first_row) begin
      model_row_base = row.position;
    end
    final_j = 0;
    for (int unsigned j = 0; j < w; j++) begin
      if (row.row_bits[w - 1 - j]) begin
        final_j = j;
      end
    end
    for (int unsigned j = 0; j < w; j++) begin
      if (row.row_bits[w - 1 - j]) begin
        for (int unsigned y = 0; y < s; y++) begin
          sp.address   = ADDR_W'(model_row_base + j * pix + y * LINE_BYTES);
          sp.nbytes    = SPANB_W'(pix);
          sp.color     = row.color;
          sp.last_span = (j == final_j) && (y == s - 1);
          expected_spans.push_back(sp);
        end
      end
    end
    model_row_base = ADDR_W'(model_row_base + s * LINE_BYTES);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // Driver: offer the next pending row once the slot is free. The payload
  // holds while stalled; after each transaction wait the drawn gap.
  always @(posedge clk) begin : row_driver
    sprite_row_t row;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (idle_left > 0) begin
        in_valid  <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_rows.size() > 0) begin
        row = pending_rows.pop_front();
        in_row_bits  <= row.row_bits;
        in_first_row <= row.first_row;
        in_position  <= row.position;
        in_color     <= row.color;
        in_valid     <= 1'b1;
        idle_left    <= $urandom_range(0, sender_max_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold: count it down in its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold_left <= 0;
    end else if (long_hold_go) begin
      long_hold_left <= LONG_HOLD_CYCLES;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  // Receiver: after each span transaction draw how long to stall next
  always @(posedge clk) begin : span_sink
    int unsigned wait_n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        wait_n = $urandom_range(0, sink_max_stall);
      end else begin
        wait_n = stall_left;
      end
      if (long_hold_left > 0 || long_hold_go) begin
        out_stall  <= 1'b1;
        stall_left <= wait_n;
      end else if (wait_n > 0) begin
        out_stall  <= 1'b1;
        stall_left <= wait_n - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // Monitor: track register writes, predict on every row transaction, and
  // compare every span transaction against the oldest prediction.
  always @(posedge clk) begin : span_monitor
    span_t want;
    if (!rst_n) begin
      model_width    = WIDTH_RESET;
      model_scale    = SCALE_RESET;
      model_row_base = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SPRITE_WIDTH: model_width = cfg_wdata[WIDTH_W-1:0];
          REG_SCALE:        model_scale = cfg_wdata[SCALE_W-1:0];
          default:          ;
        endcase
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        predict_row_spans('{in_row_bits, in_first_row, in_position, in_color});
        rows_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          error_count++;
          $display("%0t: unexpected span, expected none, actual address %h bytes %h",
                   $time, out_span_address, out_span_bytes);
        end else begin
          want = expected_spans.pop_front();
          check_field("span_address", want.address, out_span_address);
          check_field("span_bytes", want.nbytes, out_span_bytes);
          check_field("span_color", want.color, out_span_color);
          check_field("last_span", want.last_span, out_last_span);
        end
        spans_checked++;
      end
    end
  end

  task automatic add_row(logic [BITS_W-1:0] bits, logic first, logic [ADDR_W-1:0] pos,
                         logic [COLOR_W-1:0] color);
    pending_rows.push_back('{bits, first, pos, color});
    rows_pushed++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_config(logic [CFG_DAT_W-1:0] width, logic [CFG_DAT_W-1:0] scale);
    write_reg(REG_SPRITE_WIDTH, width);
    write_reg(REG_SCALE, scale);
  endtask

  // Wait until every row is taken and every span seen, then let a row that
  // draws nothing run out before touching the registers.
  task automatic drain();
    while (rows_accepted != rows_pushed || expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One sprite: a first row, then rows that carry the base forward. Break the
  // sequence now and then: a missing first flag, or a restart mid-sprite.
  task automatic queue_sprite(int unsigned n_rows);
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  pos;
    logic [BITS_W-1:0]  bits;
    logic               first;
    color = COLOR_W'($urandom);
    pos = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, LAST_POS));
    for (int unsigned r = 0; r < n_rows; r++) begin
      case ($urandom_range(0, 7))
        0:       bits = '0;
        1:       bits = '1;
        2:       bits = BITS_W'(1) << $urandom_range(0, BITS_W - 1);
        default: bits = BITS_W'($urandom);
      endcase
      if (r == 0) begin
        first = ($urandom_range(0, 9) != 0);
      end else begin
        first = ($urandom_range(0, 9) == 0);
        if (first) begin
          pos = ADDR_W'($urandom);
        end
      end
      add_row(bits, first, pos, color);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    logic [CFG_DAT_W-1:0] w_cfg;
    logic [CFG_DAT_W-1:0] s_cfg;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (width 5, scale 1): base from reset, empty row,
    // unused upper bits, extreme position and colour
    add_row(16'h001F, 1'b0, 20'h12345, 24'h000000);
    add_row(16'h0000, 1'b0, 20'h00000, 24'hA5A5A5);
    add_row(16'hFFFF, 1'b1, 20'hFFFFF, 24'hFFFFFF);
    add_row(16'h0001, 1'b0, 20'h00000, 24'h5A5A5A);
    add_row(16'h0010, 1'b1, 20'(LAST_POS), 24'h123456);
    drain();

    // Full width, largest scale: 64 spans from one row, addresses wrap
    write_config(5'd16, 5'd4);
    add_row(16'hFFFF, 1'b1, 20'hFFFFF, 24'h00FF00);
    add_row(16'h8001, 1'b0, 20'h00000, 24'hFF0000);
    add_row(16'h0000, 1'b0, 20'h00000, 24'h0000FF);
    add_row(16'h5555, 1'b0, 20'h00000, 24'h808080);
    drain();

    // Width zero draws nothing; scale zero acts as one
    write_config(5'd0, 5'd0);
    add_row(16'hFFFF, 1'b0, 20'h00000, 24'h111111);
    add_row(16'h1234, 1'b1, 20'h00300, 24'h222222);
    drain();

    // Oversized width and scale saturate
    write_config(5'd31, 5'b11111);
    add_row(16'hAAAA, 1'b1, 20'h12345, 24'h333333);
    add_row(16'hFFFF, 1'b0, 20'h00000, 24'h444444);
    drain();

    // Narrowest sprite
    write_config(5'd1, 5'd2);
    add_row(16'h0001, 1'b1, 20'h00000, 24'h555555);
    add_row(16'h0002, 1'b0, 20'h00000, 24'h666666);
    add_row(16'h0001, 1'b0, 20'h00000, 24'h777777);
    drain();

    write_config(5'd16, 5'd3);
    add_row(16'h8000, 1'b0, 20'h00000, 24'h888888);
    add_row(16'h0001, 1'b1, 20'(LAST_POS), 24'h999999);
    drain();

    // Random phases: new settings each time, alternating idle patterns
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin w_cfg = 5'd16; s_cfg = 5'd4; end
        1: begin w_cfg = 5'd1;  s_cfg = 5'd1; end
        default: begin
          w_cfg = ($urandom_range(0, 9) < 7) ? CFG_DAT_W'($urandom_range(1, MAX_W))
                                             : CFG_DAT_W'($urandom_range(0, 31));
          s_cfg = {(CFG_DAT_W - SCALE_W)'($urandom),
                   SCALE_W'(($urandom_range(0, 3) != 0) ? $urandom_range(1, MAX_S)
                                                         : $urandom_range(0, 7))};
        end
      endcase
      write_config(w_cfg, s_cfg);
      case (p % 3)
        0: begin sender_max_gap = 0; sink_max_stall = 0; end
        1: begin sender_max_gap = 8; sink_max_stall = 8; end
        default: begin sender_max_gap = 8; sink_max_stall = 2; end
      endcase
      // Halfway through, stop the receiver for a long stretch while rows
      // keep coming, so the block backs up and stalls its input
      if (p == RANDOM_PHASES / 2) begin
        sender_max_gap = 0;
        @(posedge clk);
        long_hold_go <= 1'b1;
        @(posedge clk);
        long_hold_go <= 1'b0;
      end
      phase_start = rows_pushed;
      while (rows_pushed - phase_start < PHASE_ROWS) begin
        queue_sprite($urandom_range(1, 8));
      end
      drain();
    end

    $display("Checked %0d spans from %0d sprite rows over %0d register writes,",
             spans_checked, rows_accepted, cfg_writes);
    $display("including width and scale extremes, empty rows and a long output hold.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard limit well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timeout with %0d rows pending and %0d spans expected",
             rows_pushed - rows_accepted, expected_spans.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
